// File: src/cc_pkg.sv
// Shared constants, types and helpers of the 3x3 RGB convolution unit.
`timescale 1ns / 1ps
package cc_pkg;

  // Frame limits and counter widths.
  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 2048;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight) + 1;
  localparam int DimW      = 12;

  // Divider chain sizing: a product magnitude is at most 128 * 255.
  localparam int NumW      = 15;
  localparam int DivW      = 12;
  localparam int DivSteps  = NumW;

  // Register indexes of the configuration port.
  localparam logic [2:0] RegWidth      = 3'd0;
  localparam logic [2:0] RegHeight     = 3'd1;
  localparam logic [2:0] RegKernAbove  = 3'd2;
  localparam logic [2:0] RegKernCenter = 3'd3;
  localparam logic [2:0] RegKernBelow  = 3'd4;
  localparam logic [2:0] RegDivisor    = 3'd5;

  // One term travelling down the divider chain.
  typedef struct packed {
    logic            valid;
    logic            neg;
    logic [1:0]      ch;
    logic [DivW-1:0] rem;
    logic [NumW-1:0] num;
  } div_cell_t;

  // Picks byte 0 (bits 23..16), 1 (15..8) or 2 (7..0) of a 24-bit word.
  function automatic logic [7:0] byte_sel(input logic [23:0] w, input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = w[23:16];
      2'd1:    r = w[15:8];
      default: r = w[7:0];
    endcase
    return r;
  endfunction

endpackage

// File: src/cc_div_cell.sv
// One restoring division step, registered, for the divider chain.
`timescale 1ns / 1ps
module cc_div_cell
  import cc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [DivW-1:0] dmag_i,
  input  div_cell_t       cell_i,
  output div_cell_t       cell_o
);

  logic [DivW:0] trial;
  logic          qbit;
  div_cell_t     cell_d;
  div_cell_t     cell_q;

  // Shift in the next dividend bit and subtract when it fits.
  always_comb begin
    trial  = {cell_i.rem, cell_i.num[NumW-1]};
    qbit   = (trial >= {1'b0, dmag_i});
    cell_d = cell_i;
    cell_d.rem = qbit ? DivW'(trial - {1'b0, dmag_i}) : trial[DivW-1:0];
    cell_d.num = {cell_i.num[NumW-2:0], qbit};
  end

  // Hand the partial result to the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// File: src/cc_div_chain.sv
// Row of division cells; one term enters and one quotient leaves per cycle.
`timescale 1ns / 1ps
module cc_div_chain
  import cc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [DivW-1:0] dmag_i,
  input  div_cell_t       term_i,
  output div_cell_t       quot_o
);

  div_cell_t link [DivSteps+1];

  assign link[0] = term_i;

  // Each cell hands its partial remainder to the next one.
  for (genvar g = 0; g < DivSteps; g++) begin : g_cell
    cc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .dmag_i (dmag_i),
      .cell_i (link[g]),
      .cell_o (link[g+1])
    );
  end

  assign quot_o = link[DivSteps];

endmodule

// File: src/conv3x3_rgb_clamp_unit.sv
// Top level of the streaming 3x3 RGB convolution unit with clamping.
// A drain ignored before frame end is dropped while idle; any other item without a result
// passes the read state only. An item that yields a result passes the read, neighborhood,
// run and output states, and no request is taken until its result is offered: 27 terms pass
// one per cycle through a 15-cell division chain, then the sums are clamped; a held result stalls this.
// rst_ni clears control state, window and counters; line stores are not cleared.
`timescale 1ns / 1ps
module conv3x3_rgb_clamp_unit
  import cc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
  input  logic        s_axis_tuser,   // drain
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // red_out, green_out, blue_out
  output logic        m_axis_tlast,   // frame_last
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [23:0] cfg_data_i
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StNb   = 3'd2;
  localparam logic [2:0] StRun  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;
  localparam int         Terms  = 27;
  localparam int         AccW   = 20;

  logic [2:0]      state_q;
  logic [DimW-1:0] cfg_w_q, cfg_h_q;
  logic [23:0]     kern_q [3];
  logic [DivW-1:0] cfg_div_q;
  logic [ColW-1:0] cx_q;
  logic [RowW-1:0] cy_q;
  logic [23:0]     win_q [9];
  logic [23:0]     nb_q  [9];
  logic [23:0]     pix_q;
  logic [47:0]     rd_q;
  logic [47:0]     line_mem [MaxWidth];
  logic            xl_q, xr_q, yb_q, yt_q;
  logic [1:0]      ch_q, r_q, c_q;
  logic [4:0]      iss_cnt_q, done_cnt_q;
  logic signed [AccW-1:0] acc_q [3];
  div_cell_t       term_q, quot;
  logic            accept, pending, ignore;
  logic [DimW-1:0] w_eff, h_eff;
  logic [DivW-1:0] dmag;
  logic            dneg;

  // Effective frame size and divisor magnitude.
  always_comb begin
    w_eff = (cfg_w_q == '0) ? DimW'(1) :
            (cfg_w_q > DimW'(MaxWidth)) ? DimW'(MaxWidth) : cfg_w_q;
    h_eff = (cfg_h_q == '0) ? DimW'(1) :
            (cfg_h_q > DimW'(MaxHeight)) ? DimW'(MaxHeight) : cfg_h_q;
    dneg  = cfg_div_q[DivW-1];
    dmag  = (cfg_div_q == '0) ? DivW'(1) : (dneg ? DivW'(-cfg_div_q) : cfg_div_q);
  end

  assign s_axis_tready = (state_q == StIdle);
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign pending = ({1'b0, cy_q} >= {1'b0, h_eff});
  assign ignore  = !pending && s_axis_tuser;

  // Line store holding {two rows back, one row back} per column.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= line_mem[cx_q];
    end
    if (state_q == StRead) begin
      line_mem[cx_q] <= {rd_q[23:0], pix_q};
    end
  end

  // Position and edge flags of the pixel whose result is due.
  logic            rd_valid;
  logic [DimW-1:0] tx, ty;
  logic [DimW-1:0] cx_ext, cx_inc;
  always_comb begin
    cx_ext = DimW'(cx_q);
    cx_inc = cx_ext + DimW'(1);
    if (cx_q == '0) begin
      rd_valid = (cy_q >= RowW'(2));
      tx       = w_eff - DimW'(1);
      ty       = DimW'(cy_q - RowW'(2));
    end else begin
      rd_valid = (cy_q >= RowW'(1));
      tx       = cx_ext - DimW'(1);
      ty       = DimW'(cy_q - RowW'(1));
    end
  end

  // Combinational payload feeding the term: product of coefficient and channel.
  logic signed [16:0] prod;
  logic [16:0]        pmag;
  logic [23:0]        nb_sel;
  always_comb begin
    nb_sel = nb_q[{2'b0, r_q} * 4'd3 + {2'b0, c_q}];
    prod   = $signed(byte_sel(kern_q[r_q], c_q)) *
             $signed({9'b0, byte_sel(nb_sel, ch_q)});
    pmag   = prod[16] ? 17'(-prod) : prod;
  end

  // Control sequencer, counters, window and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      cfg_w_q    <= DimW'(1);
      cfg_h_q    <= DimW'(1);
      kern_q[0]  <= '0;
      kern_q[1]  <= 24'h010000;
      kern_q[2]  <= '0;
      cfg_div_q  <= DivW'(1);
      cx_q       <= '0;
      cy_q       <= '0;
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
      iss_cnt_q  <= '0;
      done_cnt_q <= '0;
      term_q.valid <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // Configuration writes.
      if (cfg_we_i) begin
        case (cfg_addr_i)
          RegWidth:      begin cfg_w_q <= cfg_data_i[DimW-1:0]; cx_q <= '0; cy_q <= '0; end
          RegHeight:     begin cfg_h_q <= cfg_data_i[DimW-1:0]; cx_q <= '0; cy_q <= '0; end
          RegKernAbove:  kern_q[0] <= cfg_data_i;
          RegKernCenter: kern_q[1] <= cfg_data_i;
          RegKernBelow:  kern_q[2] <= cfg_data_i;
          RegDivisor:    cfg_div_q <= cfg_data_i[DivW-1:0];
          default:       ;
        endcase
      end

      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      term_q.valid <= 1'b0;

      case (state_q)
        StIdle: begin
          if (accept && !ignore) begin
            state_q <= StRead;
          end
        end
        StRead: begin
          for (int i = 0; i < 6; i++) win_q[i] <= win_q[i+3];
          win_q[6] <= rd_q[47:24];
          win_q[7] <= rd_q[23:0];
          win_q[8] <= pix_q;
          xl_q <= (tx == '0);
          xr_q <= (tx == w_eff - DimW'(1));
          yb_q <= (ty == '0);
          yt_q <= (ty == h_eff - DimW'(1));
          if (rd_valid && (tx == w_eff - DimW'(1)) && (ty == h_eff - DimW'(1))) begin
            cx_q <= '0;
            cy_q <= '0;
          end else if (cx_inc >= w_eff) begin
            cx_q <= '0;
            cy_q <= cy_q + RowW'(1);
          end else begin
            cx_q <= cx_q + ColW'(1);
          end
          state_q <= rd_valid ? StNb : StIdle;
        end
        StNb: begin
          iss_cnt_q  <= '0;
          done_cnt_q <= '0;
          state_q    <= StRun;
        end
        StRun: begin
          if (iss_cnt_q != 5'(Terms)) begin
            term_q.valid <= 1'b1;
            term_q.neg   <= prod[16] ^ dneg;
            term_q.ch    <= ch_q;
            term_q.rem   <= '0;
            term_q.num   <= pmag[NumW-1:0];
            iss_cnt_q    <= iss_cnt_q + 5'd1;
          end
          if (quot.valid) begin
            done_cnt_q <= done_cnt_q + 5'd1;
          end
          if (done_cnt_q == 5'(Terms)) begin
            state_q <= StOut;
          end
        end
        StOut: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            state_q       <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Neighborhood with edge replacement, built from the updated window.
  function automatic logic [23:0] avg_pix(input logic [23:0] p, input logic [23:0] q);
    logic [23:0] r;
    for (int c = 0; c < 3; c++) begin
      r[c*8 +: 8] = 8'(({1'b0, p[c*8 +: 8]} + {1'b0, q[c*8 +: 8]}) >> 1);
    end
    return r;
  endfunction

  logic [23:0] n00, n01, n02, n10, n11, n12, n20, n21, n22;
  always_comb begin
    n11 = win_q[4];
    n01 = yt_q ? n11 : win_q[5];
    n10 = xl_q ? n11 : win_q[1];
    n12 = xr_q ? n11 : win_q[7];
    n21 = yb_q ? n11 : win_q[3];
    n00 = xl_q ? n01 : (yt_q ? n10 : win_q[2]);
    n02 = xr_q ? n01 : (yt_q ? n12 : win_q[8]);
    n20 = xl_q ? n21 : (yb_q ? n10 : win_q[0]);
    n22 = xr_q ? n21 : (yb_q ? n12 : win_q[6]);
    if (xl_q && yt_q) n00 = avg_pix(n10, n01);
    if (xl_q && yb_q) n20 = avg_pix(n10, n21);
    if (xr_q && yt_q) n02 = avg_pix(n12, n01);
    if (xr_q && yb_q) n22 = avg_pix(n12, n21);
  end

  // Pixel, neighborhood, term indexes, sums and the result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q <= pending ? 24'h0 : {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
    end
    if (state_q == StNb) begin
      nb_q[0] <= n00; nb_q[1] <= n01; nb_q[2] <= n02;
      nb_q[3] <= n10; nb_q[4] <= n11; nb_q[5] <= n12;
      nb_q[6] <= n20; nb_q[7] <= n21; nb_q[8] <= n22;
      ch_q <= '0;
      r_q  <= '0;
      c_q  <= '0;
      for (int i = 0; i < 3; i++) acc_q[i] <= '0;
    end
    if (state_q == StRun && iss_cnt_q != 5'(Terms)) begin
      if (c_q == 2'd2) begin
        c_q <= '0;
        if (r_q == 2'd2) begin
          r_q  <= '0;
          ch_q <= ch_q + 2'd1;
        end else begin
          r_q <= r_q + 2'd1;
        end
      end else begin
        c_q <= c_q + 2'd1;
      end
    end
    if (state_q == StRun && quot.valid) begin
      acc_q[quot.ch] <= quot.neg ? acc_q[quot.ch] - AccW'(quot.num)
                                 : acc_q[quot.ch] + AccW'(quot.num);
    end
    if (state_q == StOut && (!m_axis_tvalid || m_axis_tready)) begin
      for (int i = 0; i < 3; i++) begin
        m_axis_tdata[i*8 +: 8] <= acc_q[i][AccW-1] ? 8'd0 :
                                  (acc_q[i] > AccW'(255)) ? 8'd255 : acc_q[i][7:0];
      end
      m_axis_tlast <= xr_q && yt_q;
    end
  end

  cc_div_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .dmag_i (dmag),
    .term_i (term_q),
    .quot_o (quot)
  );

endmodule

// File: src/cc_checker.sv
// Port-level checker for the convolution unit, bound to the top level.
`timescale 1ns / 1ps
module cc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // A held result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A held result keeps its data.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  // A pixel request makes the unit busy in the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !s_axis_tready)
    else $error("unit took a request while busy");

  // No result can appear right after a request.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

endmodule

bind conv3x3_rgb_clamp_unit cc_checker u_cc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: test/tb.sv
// Self-checking testbench of the streaming 3x3 RGB convolution unit.
`timescale 1ns / 1ps
module tb;
  import cc_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       drain;
  } pixel_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_res_t;

  localparam int WatchdogLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_addr_i = '0;
  logic [23:0] cfg_data_i = '0;

  pixel_req_t pixel_q[$];
  pixel_res_t filtered_q[$];
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int hold_off_reqs = 0;
  int pixel_count = 0;
  int error_count = 0;

  // Shadow state of the filter.
  logic [23:0] shadow_cfg[6];
  logic [23:0] row_mem_a[MaxWidth];
  logic [23:0] row_mem_b[MaxWidth];
  logic [23:0] win[9];
  int          col_pos;
  int          row_pos;

  conv3x3_rgb_clamp_unit DUT (.*);

  always #5 clk_i = ~clk_i;

  function automatic int clamp_dim(input logic [23:0] v);
    int d;
    d = int'(v[11:0]);
    if (d == 0) return 1;
    return (d > MaxWidth) ? MaxWidth : d;
  endfunction

  function automatic logic [7:0] chan(input logic [23:0] p, input int c);
    return p[23-8*c -: 8];
  endfunction

  function automatic logic [23:0] avg_pix(input logic [23:0] p, input logic [23:0] q);
    logic [23:0] r;
    for (int c = 0; c < 3; c++) r[23-8*c -: 8] = 8'((9'(chan(p, c)) + 9'(chan(q, c))) >> 1);
    return r;
  endfunction

  // Advances the shadow filter by one accepted request; returns 1 if a pixel comes out.
  function automatic bit filter_step(input pixel_req_t it, output pixel_res_t res);
    int w, h, cx, cy, idx, tx, ty, dv, acc;
    bit pending, valid, xl, xr, yb, yt;
    logic [23:0] pix, a, b;
    logic [23:0] nb[3][3];
    logic [7:0] out_ch[3];
    w = clamp_dim(shadow_cfg[RegWidth]);
    h = clamp_dim(shadow_cfg[RegHeight]);
    cx = col_pos;
    cy = row_pos;
    pending = cy >= h;
    res = '0;
    if (!pending && it.drain) return 0;
    pix = pending ? 24'd0 : {it.red, it.green, it.blue};
    idx = (cx < MaxWidth) ? cx : 0;
    a = row_mem_a[idx];
    b = row_mem_b[idx];
    row_mem_a[idx] = b;
    row_mem_b[idx] = pix;
    for (int i = 0; i < 6; i++) win[i] = win[i+3];
    win[6] = a;
    win[7] = b;
    win[8] = pix;
    if (cx == 0) begin
      valid = cy >= 2; tx = w - 1; ty = cy - 2;
    end else begin
      valid = cy >= 1; tx = cx - 1; ty = cy - 1;
    end
    if (cx + 1 >= w) begin
      col_pos = 0; row_pos = cy + 1;
    end else begin
      col_pos = cx + 1;
    end
    if (!valid) return 0;
    xl = tx == 0; xr = tx == w - 1; yb = ty == 0; yt = ty == h - 1;
    // Edge replacement: rows above/center/below, columns left/mid/right.
    nb[1][1] = win[4];
    nb[0][1] = yt ? nb[1][1] : win[5];
    nb[1][0] = xl ? nb[1][1] : win[1];
    nb[1][2] = xr ? nb[1][1] : win[7];
    nb[2][1] = yb ? nb[1][1] : win[3];
    nb[0][0] = xl ? nb[0][1] : (yt ? nb[1][0] : win[2]);
    nb[0][2] = xr ? nb[0][1] : (yt ? nb[1][2] : win[8]);
    nb[2][0] = xl ? nb[2][1] : (yb ? nb[1][0] : win[0]);
    nb[2][2] = xr ? nb[2][1] : (yb ? nb[1][2] : win[6]);
    if (xl && yt) nb[0][0] = avg_pix(nb[1][0], nb[0][1]);
    if (xl && yb) nb[2][0] = avg_pix(nb[1][0], nb[2][1]);
    if (xr && yt) nb[0][2] = avg_pix(nb[1][2], nb[0][1]);
    if (xr && yb) nb[2][2] = avg_pix(nb[1][2], nb[2][1]);
    dv = int'($signed(shadow_cfg[RegDivisor][11:0]));
    if (dv == 0) dv = 1;
    for (int c = 0; c < 3; c++) begin
      acc = 0;
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++)
          acc += (int'($signed(shadow_cfg[RegKernAbove + r][23-8*k -: 8]))
                  * int'(chan(nb[r][k], c))) / dv;
      if (acc < 0) acc = 0;
      if (acc > 255) acc = 255;
      out_ch[c] = 8'(acc);
    end
    res.red = out_ch[0];
    res.green = out_ch[1];
    res.blue = out_ch[2];
    res.last = xr && yt;
    if (xr && yt) begin
      col_pos = 0; row_pos = 0;
    end
    return 1;
  endfunction

  // Request driver: presents the head of the pending queue, drops valid at random.
  always @(posedge clk_i) begin
    pixel_res_t r;
    bit hold;
    hold = 1'b0;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (filter_step(pixel_q[0], r)) filtered_q.push_back(r);
        void'(pixel_q.pop_front());
      end else if (s_axis_tvalid) begin
        hold = 1'b1;
      end
      if (hold) begin
        s_axis_tvalid <= 1'b1;
      end else if (pixel_q.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pixel_q[0].blue, pixel_q[0].green, pixel_q[0].red};
        s_axis_tuser  <= pixel_q[0].drain;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor with random stalls and a long hold-off on request.
  always @(posedge clk_i) begin
    static int hold_left = 0;
    static int hold_seen = 0;
    pixel_res_t e;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (filtered_q.size() == 0) begin
          $error("unexpected result %h last %b", m_axis_tdata, m_axis_tlast);
          error_count++;
        end else begin
          e = filtered_q.pop_front();
          if (m_axis_tdata[7:0] !== e.red) begin
            $error("red_out: expected %0d, got %0d", e.red, m_axis_tdata[7:0]);
            error_count++;
          end
          if (m_axis_tdata[15:8] !== e.green) begin
            $error("green_out: expected %0d, got %0d", e.green, m_axis_tdata[15:8]);
            error_count++;
          end
          if (m_axis_tdata[23:16] !== e.blue) begin
            $error("blue_out: expected %0d, got %0d", e.blue, m_axis_tdata[23:16]);
            error_count++;
          end
          if (m_axis_tlast !== e.last) begin
            $error("frame_last: expected %0b, got %0b", e.last, m_axis_tlast);
            error_count++;
          end
        end
      end
      if (hold_seen != hold_off_reqs) begin
        hold_seen = hold_off_reqs;
        hold_left = 400;
      end
      if (hold_left > 0) hold_left--;
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Watchdog on cycles without progress while work is outstanding.
  always @(posedge clk_i) begin
    static int quiet = 0;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (pixel_q.size() == 0 && filtered_q.size() == 0)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WatchdogLimit) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    shadow_cfg[idx] = (idx == RegKernAbove || idx == RegKernCenter || idx == RegKernBelow)
                      ? val : {12'd0, val[11:0]};
    if (idx == RegWidth || idx == RegHeight) begin
      col_pos = 0; row_pos = 0;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pixel_q.size() > 0 || filtered_q.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic configure(input logic [11:0] w, input logic [11:0] h, input logic [23:0] ka,
                           input logic [23:0] kc, input logic [23:0] kb, input logic [11:0] dv);
    write_reg(RegWidth, {12'd0, w});
    write_reg(RegHeight, {12'd0, h});
    write_reg(RegKernAbove, ka);
    write_reg(RegKernCenter, kc);
    write_reg(RegKernBelow, kb);
    write_reg(RegDivisor, {12'd0, dv});
  endtask

  function automatic pixel_req_t rand_pixel();
    pixel_req_t p;
    p.red = 8'($urandom);
    p.green = 8'($urandom);
    p.blue = 8'($urandom);
    p.drain = 1'b0;
    if ($urandom_range(7) == 0) p = {p.red | 8'hF0, p.green & 8'h0F, p.blue ^ 8'hFF, 1'b0};
    return p;
  endfunction

  // Queues one frame plus the flush that brings out its last pixel.
  task automatic queue_frame(input bit noise);
    int w, h;
    pixel_req_t p;
    w = clamp_dim(shadow_cfg[RegWidth]);
    h = clamp_dim(shadow_cfg[RegHeight]);
    for (int i = 0; i < w * h; i++) begin
      if (noise && $urandom_range(15) == 0) begin
        p = rand_pixel();
        p.drain = 1'b1;
        pixel_q.push_back(p);
      end
      pixel_q.push_back(rand_pixel());
      pixel_count++;
    end
    // Flush items; a pixel after frame end acts as a drain too.
    for (int i = 0; i <= w; i++) begin
      p = rand_pixel();
      p.drain = noise ? 1'($urandom_range(1)) : 1'b1;
      pixel_q.push_back(p);
      pixel_count++;
    end
  endtask

  function automatic logic [11:0] rand_divisor();
    case ($urandom_range(7))
      0: return 12'h800;
      1: return 12'h7FF;
      2: return 12'h000;
      3: return 12'hFFF;
      default: return 12'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [23:0] rand_kernel();
    if ($urandom_range(2) == 0) return 24'($urandom);
    return {8'($signed($urandom_range(0, 6)) - 3), 8'($signed($urandom_range(0, 6)) - 3),
            8'($signed($urandom_range(0, 6)) - 3)};
  endfunction

  initial begin
    int phase;
    shadow_cfg[RegWidth] = 24'd1;
    shadow_cfg[RegHeight] = 24'd1;
    shadow_cfg[RegKernAbove] = 24'd0;
    shadow_cfg[RegKernCenter] = 24'h010000;
    shadow_cfg[RegKernBelow] = 24'd0;
    shadow_cfg[RegDivisor] = 24'd1;
    for (int i = 0; i < MaxWidth; i++) begin
      row_mem_a[i] = '0; row_mem_b[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    col_pos = 0;
    row_pos = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset settings, a drain before frame end, magenta and green pixels.
    pixel_q.push_back('{8'd0, 8'd0, 8'd0, 1'b1});
    pixel_q.push_back('{8'hFF, 8'h00, 8'hFF, 1'b0});
    pixel_q.push_back('{8'd0, 8'd0, 8'd0, 1'b1});
    pixel_q.push_back('{8'h00, 8'hFF, 8'h00, 1'b0});
    wait_idle();
    // A 3x3 box blur reaches every corner and edge rule.
    configure(12'd3, 12'd3, 24'h010101, 24'h010101, 24'h010101, 12'd9);
    pixel_q.push_back('{8'hFF, 8'hFF, 8'hFF, 1'b0});
    pixel_q.push_back('{8'h00, 8'h00, 8'h00, 1'b0});
    pixel_q.push_back('{8'hFF, 8'h00, 8'h80, 1'b0});
    for (int i = 0; i < 6; i++) pixel_q.push_back(rand_pixel());
    for (int i = 0; i < 4; i++) pixel_q.push_back('{8'h12, 8'h34, 8'h56, 1'b1});
    wait_idle();
    // Most negative and most positive coefficients, most negative divisor, zero dimensions.
    configure(12'd0, 12'd0, 24'h808080, 24'h7F7F7F, 24'h808080, 12'h800);
    pixel_q.push_back('{8'hFF, 8'hFF, 8'hFF, 1'b0});
    pixel_q.push_back('{8'd0, 8'd0, 8'd0, 1'b1});
    pixel_q.push_back('{8'd0, 8'd0, 8'd0, 1'b1});
    wait_idle();

    // Random frames through the idling phases.
    phase = 0;
    while (pixel_count < 1250) begin
      case (phase % 4)
        0: begin in_idle_pct = 0;  out_idle_pct = 0;  end
        1: begin in_idle_pct = 55; out_idle_pct = 0;  end
        2: begin in_idle_pct = 0;  out_idle_pct = 55; end
        default: begin in_idle_pct = 22; out_idle_pct = 22; end
      endcase
      configure(12'($urandom_range(1, 8)), 12'($urandom_range(1, 6)), rand_kernel(),
                rand_kernel(), rand_kernel(), rand_divisor());
      if (phase == 5) hold_off_reqs++;
      queue_frame(1'b1);
      wait_idle();
      phase++;
    end

    // Height saturating: the first rows of a one-column frame.
    in_idle_pct = 0;
    out_idle_pct = 0;
    configure(12'd1, 12'hFFF, rand_kernel(), rand_kernel(), rand_kernel(), 12'hFFE);
    for (int i = 0; i < 60; i++) begin
      pixel_q.push_back(rand_pixel());
      pixel_count++;
    end
    wait_idle();

    repeat (100) @(posedge clk_i);
    if (error_count == 0 && filtered_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
